>>> hw/rtl/tpcd_pkg.sv
// ----------------------------------------------------------------------------
// tpcd_pkg
// Shared types and constants of the tracker pattern cell decoder.
// ----------------------------------------------------------------------------
package tpcd_pkg;

    localparam int CHANNELS = 8;
    localparam int MAX_ROWS = 64;
    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic [7:0] NO_EFFECT     = 8'hff;
    localparam logic [7:0] VOLUME_ONLY   = 8'hfe;
    localparam logic [7:0] KEEP_EFFECT   = 8'h30;
    localparam logic [7:0] PAN_LEFT      = 8'h4f;
    localparam logic [7:0] PAN_RIGHT     = 8'hf4;
    localparam logic [3:0] FINE_NIBBLE   = 4'hf;
    localparam logic [6:0] NOTE_OFFSET   = 7'd37;
    localparam logic [6:0] SHORT_PATTERN = 7'd32;

    // result effect codes
    localparam logic [3:0] FX_NONE       = 4'd0;
    localparam logic [3:0] FX_SLIDE_UP   = 4'd1;
    localparam logic [3:0] FX_SLIDE_DOWN = 4'd2;
    localparam logic [3:0] FX_TONE_SLIDE = 4'd3;
    localparam logic [3:0] FX_CHORD      = 4'd4;
    localparam logic [3:0] FX_TEMPO      = 4'd5;
    localparam logic [3:0] FX_PAN_SLIDE  = 4'd6;
    localparam logic [3:0] FX_REPEAT     = 4'd7;
    localparam logic [3:0] FX_BREAK      = 4'd8;

    // source effect commands (high nibble of the effect byte)
    localparam logic [3:0] CMD_SLIDE_UP   = 4'd0;
    localparam logic [3:0] CMD_SLIDE_DOWN = 4'd1;
    localparam logic [3:0] CMD_TONE_SLIDE = 4'd2;
    localparam logic [3:0] CMD_FREQ_ADJ   = 4'd3;
    localparam logic [3:0] CMD_ARPEGGIO   = 4'd4;
    localparam logic [3:0] CMD_SET_TEMPO  = 4'd5;
    localparam logic [3:0] CMD_BALANCE    = 4'd6;
    localparam logic [3:0] CMD_RETRIG     = 4'd7;

    localparam logic [3:0] BAL_LEFT  = 4'd0;
    localparam logic [3:0] BAL_RIGHT = 4'd1;

    typedef struct packed {
        logic [7:0] note_byte;
        logic [7:0] volume_byte;
        logic [7:0] effect_byte;
        logic [2:0] channel;
        logic [5:0] row;
        logic [6:0] row_count;
        logic [7:0] pattern_speed;
    } t_cell_in;

    typedef struct packed {
        logic       note_valid;
        logic [6:0] note_value;
        logic [6:0] instrument;
        logic       volume_valid;
        logic [5:0] volume_level;
        logic [3:0] effect_code;
        logic [7:0] effect_param;
    } t_cell_out;

    // classified cell, passed from front to back
    typedef struct packed {
        logic            note_valid;
        logic [6:0]      note_value;
        logic [6:0]      instrument;
        logic            volume_valid;
        logic [5:0]      volume_level;
        logic            fx_given;
        logic            fx_clear;
        logic [7:0]      effect_byte;
        logic            has_slot;
        logic [CH_W-1:0] slot;
        logic            row_zero;
        logic            pattern_start;
        logic            break_row;
        logic [7:0]      pattern_speed;
    } t_cls;

endpackage

>>> hw/rtl/tpcd_front.sv
// ----------------------------------------------------------------------------
// tpcd_front
// Accepts cells, decodes note and volume, classifies the effect byte and the
// row position, and holds the results in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module tpcd_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  tpcd_pkg::t_cell_in i_cell,
    output logic               o_head_valid,
    output tpcd_pkg::t_cls     o_head,
    input  logic               i_head_take
);

    tpcd_pkg::t_cls c_cls;
    tpcd_pkg::t_cls r_q [2];
    logic           r_wr;
    logic           r_rd;
    logic [1:0]     r_cnt;
    logic           n_wr;
    logic           n_rd;
    logic [1:0]     n_cnt;
    logic           w_push;
    logic           w_take;
    logic           w_note;
    logic [6:0]     w_row_inc;

    always_comb begin
        w_note    = (i_cell.note_byte != tpcd_pkg::VOLUME_ONLY) &&
                    (i_cell.note_byte != tpcd_pkg::NO_EFFECT);
        w_row_inc = {1'b0, i_cell.row} + 7'd1;

        c_cls.note_valid   = w_note;
        c_cls.note_value   = w_note ? ({1'b0, i_cell.note_byte[7:2]} + tpcd_pkg::NOTE_OFFSET)
                                    : 7'd0;
        c_cls.instrument   = w_note ? ({1'b0, i_cell.note_byte[1:0], i_cell.volume_byte[7:4]}
                                       + 7'd1) : 7'd0;
        c_cls.volume_valid = (i_cell.note_byte != tpcd_pkg::NO_EFFECT);
        c_cls.volume_level = c_cls.volume_valid ? {i_cell.volume_byte[3:0], 2'b00} : 6'd0;
        c_cls.fx_given     = (i_cell.effect_byte != tpcd_pkg::NO_EFFECT);
        c_cls.fx_clear     = (i_cell.effect_byte[3:0] == 4'd0) &&
                             (i_cell.effect_byte != tpcd_pkg::KEEP_EFFECT);
        c_cls.effect_byte  = i_cell.effect_byte;
        c_cls.has_slot     = (32'(i_cell.channel) < tpcd_pkg::CHANNELS);
        c_cls.slot         = tpcd_pkg::CH_W'(i_cell.channel);
        c_cls.row_zero     = (i_cell.row == 6'd0);
        c_cls.pattern_start = (i_cell.row == 6'd0) && (i_cell.channel == 3'd0);
        c_cls.break_row    = (i_cell.row_count >= 7'd1) &&
                             (i_cell.row_count < tpcd_pkg::SHORT_PATTERN) &&
                             (32'(i_cell.row_count) <= tpcd_pkg::MAX_ROWS) &&
                             (w_row_inc == i_cell.row_count);
        c_cls.pattern_speed = i_cell.pattern_speed;
    end

    assign full         = (r_cnt == 2'd2);
    assign w_push       = push && !full;
    assign o_head_valid = (r_cnt != 2'd0);
    assign w_take       = i_head_take && o_head_valid;
    assign o_head       = r_q[r_rd];

    always_comb begin
        n_wr  = w_push ? ~r_wr : r_wr;
        n_rd  = w_take ? ~r_rd : r_rd;
        n_cnt = r_cnt + {1'b0, w_push} - {1'b0, w_take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= c_cls;
        end
    end

endmodule

>>> hw/rtl/tpcd_back.sv
// ----------------------------------------------------------------------------
// tpcd_back
// Resolves the effect against the per-channel remembered effect, inserts speed
// and break effects, and queues finished cells in a two-entry result queue.
// ----------------------------------------------------------------------------
module tpcd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_head_valid,
    input  tpcd_pkg::t_cls      i_head,
    output logic                o_head_take,
    output logic                empty,
    input  logic                pop,
    output tpcd_pkg::t_cell_out o_result
);

    logic [7:0]          r_mem [tpcd_pkg::CHANNELS];
    logic                r_speed_placed;
    logic                r_break_placed;
    logic                n_speed_placed;
    logic                n_break_placed;
    tpcd_pkg::t_cell_out r_q [2];
    logic                r_wr;
    logic                r_rd;
    logic [1:0]          r_cnt;
    logic                w_go;
    logic                w_pop;
    logic [7:0]          w_eff;
    logic [7:0]          w_store;
    logic [3:0]          w_cmd;
    logic [3:0]          w_p;
    logic [3:0]          w_code;
    logic [7:0]          w_param;
    logic                w_sp;
    logic                w_bp;
    tpcd_pkg::t_cell_out c_res;

    assign w_go        = i_head_valid && (r_cnt != 2'd2);
    assign o_head_take = w_go;
    assign empty       = (r_cnt == 2'd0);
    assign w_pop       = pop && !empty;
    assign o_result    = r_q[r_rd];

    always_comb begin
        w_eff = tpcd_pkg::NO_EFFECT;
        if (i_head.has_slot && !i_head.row_zero) begin
            w_eff = r_mem[i_head.slot];
        end
        if (i_head.note_valid) begin
            w_eff = tpcd_pkg::NO_EFFECT;
        end
        if (i_head.fx_given) begin
            w_eff = i_head.effect_byte;
        end
        if (i_head.fx_clear) begin
            w_eff = tpcd_pkg::NO_EFFECT;
        end

        w_cmd   = w_eff[7:4];
        w_p     = w_eff[3:0];
        w_store = w_eff;
        w_code  = tpcd_pkg::FX_NONE;
        w_param = 8'd0;
        unique case (w_cmd)
            tpcd_pkg::CMD_SLIDE_UP: begin
                w_code  = tpcd_pkg::FX_SLIDE_UP;
                w_param = {4'd0, w_p};
            end
            tpcd_pkg::CMD_SLIDE_DOWN: begin
                w_code  = tpcd_pkg::FX_SLIDE_DOWN;
                w_param = {4'd0, w_p};
            end
            tpcd_pkg::CMD_TONE_SLIDE: begin
                w_code  = tpcd_pkg::FX_TONE_SLIDE;
                w_param = {4'd0, w_p};
            end
            tpcd_pkg::CMD_FREQ_ADJ: begin
                w_code  = tpcd_pkg::FX_SLIDE_UP;
                w_param = {tpcd_pkg::FINE_NIBBLE, w_p};
                w_store = tpcd_pkg::NO_EFFECT;
            end
            tpcd_pkg::CMD_ARPEGGIO: begin
                w_code  = tpcd_pkg::FX_CHORD;
                w_param = {w_p, w_p};
            end
            tpcd_pkg::CMD_SET_TEMPO: begin
                w_code  = tpcd_pkg::FX_TEMPO;
                w_param = {4'd0, w_p};
                w_store = tpcd_pkg::NO_EFFECT;
            end
            tpcd_pkg::CMD_BALANCE: begin
                if (w_p == tpcd_pkg::BAL_LEFT) begin
                    w_code  = tpcd_pkg::FX_PAN_SLIDE;
                    w_param = tpcd_pkg::PAN_LEFT;
                end else if (w_p == tpcd_pkg::BAL_RIGHT) begin
                    w_code  = tpcd_pkg::FX_PAN_SLIDE;
                    w_param = tpcd_pkg::PAN_RIGHT;
                end
            end
            tpcd_pkg::CMD_RETRIG: begin
                w_code  = tpcd_pkg::FX_REPEAT;
                w_param = {4'd0, w_p};
            end
            default: begin
            end
        endcase

        // pattern start clears both placement flags before they are used
        w_sp           = i_head.pattern_start ? 1'b0 : r_speed_placed;
        w_bp           = i_head.pattern_start ? 1'b0 : r_break_placed;
        n_speed_placed = w_sp;
        n_break_placed = w_bp;

        if (i_head.row_zero && !w_sp) begin
            if (w_code == tpcd_pkg::FX_TEMPO) begin
                n_speed_placed = 1'b1;
            end else if (w_code == tpcd_pkg::FX_NONE) begin
                w_code         = tpcd_pkg::FX_TEMPO;
                w_param        = i_head.pattern_speed;
                n_speed_placed = 1'b1;
            end
        end

        if (i_head.break_row && !w_bp && (w_code == tpcd_pkg::FX_NONE)) begin
            w_code         = tpcd_pkg::FX_BREAK;
            w_param        = 8'd0;
            n_break_placed = 1'b1;
        end

        if (w_code == tpcd_pkg::FX_NONE) begin
            w_param = 8'd0;
        end

        c_res.note_valid   = i_head.note_valid;
        c_res.note_value   = i_head.note_value;
        c_res.instrument   = i_head.instrument;
        c_res.volume_valid = i_head.volume_valid;
        c_res.volume_level = i_head.volume_level;
        c_res.effect_code  = w_code;
        c_res.effect_param = w_param;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < tpcd_pkg::CHANNELS; i++) begin
                r_mem[i] <= tpcd_pkg::NO_EFFECT;
            end
            r_speed_placed <= 1'b0;
            r_break_placed <= 1'b0;
        end else if (w_go) begin
            if (i_head.has_slot) begin
                r_mem[i_head.slot] <= w_store;
            end
            r_speed_placed <= n_speed_placed;
            r_break_placed <= n_break_placed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_go) begin
                r_wr <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, w_go} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_q[r_wr] <= c_res;
        end
    end

endmodule

>>> hw/rtl/tracker_pattern_cell_decoder.sv
// ----------------------------------------------------------------------------
// tracker_pattern_cell_decoder
// Decodes three-byte tracker pattern cells into note, instrument, volume and
// a renumbered effect, with per-channel effect memory and speed/break insert.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-----------------------------
//  cells    | in        | push / full        | i_cell   (t_cell_in)
//  results  | out       | empty / pop        | o_result (t_cell_out)
//
// Sustains one cell per cycle while neither queue is full; an accepted cell
// waits in the front queue, passes the combinational back stage into the result
// queue when it heads the front queue and the result queue has room.
// Reset is synchronous on i_rst_n low: both queues drain to empty and every
// remembered effect returns to none; the speed and break flags clear.
// Front and back each stall on their own: a full result queue holds the back
// stage while the front keeps taking cells until its own queue fills.
// ----------------------------------------------------------------------------
module tracker_pattern_cell_decoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  tpcd_pkg::t_cell_in  i_cell,
    output logic                empty,
    input  logic                pop,
    output tpcd_pkg::t_cell_out o_result
);

    // classified cells between front and back
    logic           w_head_valid;
    tpcd_pkg::t_cls w_head;
    logic           w_head_take;

    // front: accept, decode note/volume, classify effect and row position
    tpcd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_cell       (i_cell),
        .o_head_valid (w_head_valid),
        .o_head       (w_head),
        .i_head_take  (w_head_take)
    );

    // back: resolve remembered effect, insert speed/break, queue the transfer
    tpcd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_head_take  (w_head_take),
        .empty        (empty),
        .pop          (pop),
        .o_result     (o_result)
    );

endmodule

>>> bench/cell_decode_checker.sv
// ----------------------------------------------------------------------------
// cell_decode_checker
// Watches both queue channels of the pattern cell decoder, predicts each
// decoded cell from the accepted input cells and compares field by field.
// ----------------------------------------------------------------------------
module cell_decode_checker
    import tpcd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  logic      i_full,
    input  t_cell_in  i_cell,
    input  logic      i_empty,
    input  logic      i_pop,
    input  t_cell_out i_result,
    output int        o_pending,
    output int        o_results,
    output int        o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] EMPTY_CELL = 8'hff;

    logic [7:0] chan_effect [CHANNELS];
    logic       speed_done;
    logic       break_done;
    t_cell_out  decoded_cells [$];
    int         results_seen = 0;
    int         fail_count   = 0;

    initial begin
        o_pending = 0;
        o_results = 0;
        o_errors  = 0;
    end

    function automatic t_cell_out predict_decoded_cell(input t_cell_in c);
        t_cell_out  r;
        logic [7:0] fx;
        logic [3:0] nib;
        logic       slot_ok;
        r       = '0;
        slot_ok = (int'(c.channel) < CHANNELS);
        // channel 0 on row 0 opens a new pattern
        if (c.row == 6'd0 && c.channel == 3'd0) begin
            speed_done = 1'b0;
            break_done = 1'b0;
        end
        fx = NO_EFFECT;
        if (slot_ok && c.row != 6'd0) begin
            fx = chan_effect[c.channel];
        end
        if (c.note_byte == VOLUME_ONLY) begin
            r.volume_valid = 1'b1;
            r.volume_level = {c.volume_byte[3:0], 2'b00};
        end else if (c.note_byte != EMPTY_CELL) begin
            r.note_valid   = 1'b1;
            r.note_value   = {1'b0, c.note_byte[7:2]} + NOTE_OFFSET;
            r.instrument   = {1'b0, c.note_byte[1:0], c.volume_byte[7:4]} + 7'd1;
            r.volume_valid = 1'b1;
            r.volume_level = {c.volume_byte[3:0], 2'b00};
            fx             = NO_EFFECT;
        end
        if (c.effect_byte != NO_EFFECT) begin
            fx = c.effect_byte;
        end
        if (c.effect_byte[3:0] == 4'd0 && c.effect_byte != KEEP_EFFECT) begin
            fx = NO_EFFECT;
        end
        if (fx != NO_EFFECT) begin
            nib = fx[3:0];
            case (fx[7:4])
                CMD_SLIDE_UP: begin
                    r.effect_code  = FX_SLIDE_UP;
                    r.effect_param = {4'd0, nib};
                end
                CMD_SLIDE_DOWN: begin
                    r.effect_code  = FX_SLIDE_DOWN;
                    r.effect_param = {4'd0, nib};
                end
                CMD_TONE_SLIDE: begin
                    r.effect_code  = FX_TONE_SLIDE;
                    r.effect_param = {4'd0, nib};
                end
                CMD_FREQ_ADJ: begin
                    r.effect_code  = FX_SLIDE_UP;
                    r.effect_param = {FINE_NIBBLE, nib};
                    fx             = NO_EFFECT;
                end
                CMD_ARPEGGIO: begin
                    r.effect_code  = FX_CHORD;
                    r.effect_param = {nib, nib};
                end
                CMD_SET_TEMPO: begin
                    r.effect_code  = FX_TEMPO;
                    r.effect_param = {4'd0, nib};
                    fx             = NO_EFFECT;
                end
                CMD_BALANCE: begin
                    if (nib == BAL_LEFT) begin
                        r.effect_code  = FX_PAN_SLIDE;
                        r.effect_param = PAN_LEFT;
                    end else if (nib == BAL_RIGHT) begin
                        r.effect_code  = FX_PAN_SLIDE;
                        r.effect_param = PAN_RIGHT;
                    end
                end
                CMD_RETRIG: begin
                    r.effect_code  = FX_REPEAT;
                    r.effect_param = {4'd0, nib};
                end
                default: ;
            endcase
        end
        if (slot_ok) begin
            chan_effect[c.channel] = fx;
        end
        if (c.row == 6'd0 && !speed_done) begin
            if (r.effect_code == FX_TEMPO) begin
                speed_done = 1'b1;
            end else if (r.effect_code == FX_NONE) begin
                r.effect_code  = FX_TEMPO;
                r.effect_param = c.pattern_speed;
                speed_done     = 1'b1;
            end
        end
        if (c.row_count >= 7'd1 && c.row_count < SHORT_PATTERN &&
            int'(c.row_count) <= MAX_ROWS && {1'b0, c.row} + 7'd1 == c.row_count &&
            !break_done && r.effect_code == FX_NONE) begin
            r.effect_code  = FX_BREAK;
            r.effect_param = 8'd0;
            break_done     = 1'b1;
        end
        if (r.effect_code == FX_NONE) begin
            r.effect_param = 8'd0;
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name,
                     want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_cell_out want;
        if (!i_rst_n) begin
            foreach (chan_effect[i]) chan_effect[i] = NO_EFFECT;
            speed_done = 1'b0;
            break_done = 1'b0;
            decoded_cells.delete();
        end else begin
            // compare the outgoing transfer before queueing the incoming one
            if (i_pop && !i_empty) begin
                results_seen++;
                if (decoded_cells.size() == 0) begin
                    fail_count++;
                    $display("%0t ns: unexpected result, expected none, got 0x%0h",
                             $time, i_result);
                end else begin
                    want = decoded_cells.pop_front();
                    check_field("note_valid",   8'(want.note_valid),   8'(i_result.note_valid));
                    check_field("note_value",   8'(want.note_value),   8'(i_result.note_value));
                    check_field("instrument",   8'(want.instrument),   8'(i_result.instrument));
                    check_field("volume_valid", 8'(want.volume_valid),
                                8'(i_result.volume_valid));
                    check_field("volume_level", 8'(want.volume_level),
                                8'(i_result.volume_level));
                    check_field("effect_code",  8'(want.effect_code),  8'(i_result.effect_code));
                    check_field("effect_param", want.effect_param, i_result.effect_param);
                end
            end
            if (i_push && !i_full) begin
                decoded_cells.push_back(predict_decoded_cell(i_cell));
            end
        end
        o_pending <= decoded_cells.size();
        o_results <= results_seen;
        o_errors  <= fail_count;
    end

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives pattern cells into the tracker pattern cell decoder under changing
// sender and receiver idling; a checker beside it predicts every decoded cell.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tpcd_pkg::*;

    localparam int RESULT_HOLD_CYCLES = 200;
    localparam int PHASE_ONE_END      = 617;
    localparam int PHASE_TWO_END      = 1234;
    localparam int TOTAL_CELLS        = 1850;
    localparam int DRAIN_CYCLES       = 8;

    logic      clk;
    logic      rst_n;
    logic      cell_push;
    logic      cell_full;
    t_cell_in  cell_in;
    logic      res_empty;
    logic      res_pop;
    t_cell_out res_out;

    int        results_done;
    int        results_pending;
    int        fail_count;

    int        send_idle_pct  = 0;
    int        recv_idle_pct  = 0;
    logic      hold_results   = 1'b0;
    int        cells_sent     = 0;
    int        directed_cells = 0;
    int        pattern_cells  = 0;
    int        loose_cells    = 0;
    int        pattern_count  = 0;

    tracker_pattern_cell_decoder u_dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .push     (cell_push),
        .full     (cell_full),
        .i_cell   (cell_in),
        .empty    (res_empty),
        .pop      (res_pop),
        .o_result (res_out)
    );

    cell_decode_checker u_checker (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_push    (cell_push),
        .i_full    (cell_full),
        .i_cell    (cell_in),
        .i_empty   (res_empty),
        .i_pop     (res_pop),
        .i_result  (res_out),
        .o_pending (results_pending),
        .o_results (results_done),
        .o_errors  (fail_count)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Receiver: pop at random, or hold off for a counted stretch when asked.
    initial begin
        res_pop <= 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_results) begin
                res_pop <= 1'b0;
                repeat (RESULT_HOLD_CYCLES) @(posedge clk);
                hold_results = 1'b0;
            end else begin
                res_pop <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    function automatic t_cell_in cell_of(input logic [7:0] nb, input logic [7:0] vb,
                                         input logic [7:0] eb, input logic [2:0] ch,
                                         input logic [5:0] row, input logic [6:0] rc,
                                         input logic [7:0] spd);
        t_cell_in c;
        c.note_byte     = nb;
        c.volume_byte   = vb;
        c.effect_byte   = eb;
        c.channel       = ch;
        c.row           = row;
        c.row_count     = rc;
        c.pattern_speed = spd;
        return c;
    endfunction

    // Offer one cell, idling first at the current rate; return once full reads low, so the cell has been taken.
    task automatic send_cell(input t_cell_in c);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            cell_push <= 1'b0;
            @(posedge clk);
        end
        cell_push <= 1'b1;
        cell_in   <= c;
        @(posedge clk);
        while (cell_full) @(posedge clk);
        cells_sent++;
    endtask

    // Hold the input quiet until every queued cell has come back.
    task automatic wait_all_decoded();
        cell_push <= 1'b0;
        wait (results_done >= cells_sent);
        @(posedge clk);
    endtask

    // Cell content weighted toward notes, empties, kept effects and balance.
    function automatic t_cell_in random_cell(input int ch, input int row, input int rc,
                                             input logic [7:0] spd);
        t_cell_in c;
        int       pick;
        c = cell_of(8'hff, 8'($urandom_range(0, 255)), 8'hff, 3'(ch), 6'(row), 7'(rc),
                    spd);
        pick = $urandom_range(0, 99);
        if (pick < 40)       c.note_byte = 8'($urandom_range(0, 253));
        else if (pick < 65)  c.note_byte = 8'hff;
        else if (pick < 85)  c.note_byte = VOLUME_ONLY;
        else                 c.note_byte = 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 35)       c.effect_byte = NO_EFFECT;
        else if (pick < 45)  c.effect_byte = KEEP_EFFECT;
        else if (pick < 55)  c.effect_byte = {CMD_BALANCE, 4'($urandom_range(0, 2))};
        else if (pick < 65)  c.effect_byte = {4'($urandom_range(0, 15)), 4'd0};
        else                 c.effect_byte = 8'($urandom_range(0, 255));
        return c;
    endfunction

    // One pattern in row order; long patterns keep only their first and last rows.
    task automatic send_pattern();
        int         rc;
        int         pick;
        logic [7:0] spd;
        pick = $urandom_range(0, 99);
        if (pick < 55)       rc = $urandom_range(1, 6);
        else if (pick < 85)  rc = $urandom_range(7, 31);
        else                 rc = $urandom_range(32, MAX_ROWS);
        spd = 8'($urandom_range(0, 255));
        pattern_count++;
        for (int r = 0; r < rc; r++) begin
            if (rc <= 12 || r < 4 || r >= rc - 4) begin
                for (int ch = 0; ch < CHANNELS; ch++) begin
                    // drop a channel now and then, but never the one opening the pattern
                    if (ch == 0 || $urandom_range(0, 9) != 0) begin
                        send_cell(random_cell(ch, r, rc, spd));
                        pattern_cells++;
                    end
                end
            end
        end
    endtask

    // Loose cells with every field free, row counts past the pattern size included.
    task automatic send_noise();
        int n;
        n = $urandom_range(1, 8);
        repeat (n) begin
            send_cell(cell_of(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
                              6'($urandom_range(0, 63)), 7'($urandom_range(0, 127)),
                              8'($urandom_range(0, 255))));
            loose_cells++;
        end
    endtask

    task automatic send_random_until(input int target);
        while (cells_sent < target) begin
            if ($urandom_range(0, 99) < 85) send_pattern();
            else                            send_noise();
        end
    endtask

    task automatic send_directed();
        // two-row pattern: speed lands on channel 0, break on the first empty cell
        // of the last row
        send_cell(cell_of(8'h00, 8'h00, 8'hff, 3'd0, 6'd0, 7'd2, 8'ha5)); // lowest note
        send_cell(cell_of(8'hfd, 8'hff, 8'h30, 3'd1, 6'd0, 7'd2, 8'ha5)); // top note, 0x30
        send_cell(cell_of(8'hfe, 8'h0f, 8'h55, 3'd2, 6'd0, 7'd2, 8'ha5)); // tempo, vol only
        send_cell(cell_of(8'hff, 8'h00, 8'h41, 3'd3, 6'd0, 7'd2, 8'ha5)); // arpeggio
        send_cell(cell_of(8'hff, 8'h00, 8'h60, 3'd4, 6'd0, 7'd2, 8'ha5)); // zero balance
        send_cell(cell_of(8'hff, 8'h00, 8'h61, 3'd5, 6'd0, 7'd2, 8'ha5)); // balance right
        send_cell(cell_of(8'hff, 8'h00, 8'h62, 3'd6, 6'd0, 7'd2, 8'ha5)); // bad balance
        send_cell(cell_of(8'hff, 8'h00, 8'h7f, 3'd7, 6'd0, 7'd2, 8'ha5)); // retrig
        send_cell(cell_of(8'hff, 8'h00, 8'hff, 3'd0, 6'd1, 7'd2, 8'ha5)); // break here
        send_cell(cell_of(8'hff, 8'h00, 8'hff, 3'd3, 6'd1, 7'd2, 8'ha5)); // repeat arp
        send_cell(cell_of(8'h10, 8'h50, 8'hff, 3'd3, 6'd1, 7'd2, 8'ha5)); // note drops it
        send_cell(cell_of(8'hff, 8'h00, 8'h1f, 3'd4, 6'd1, 7'd2, 8'ha5)); // slide down
        send_cell(cell_of(8'hff, 8'h00, 8'hff, 3'd5, 6'd1, 7'd2, 8'ha5)); // repeat pan
        send_cell(cell_of(8'hff, 8'h00, 8'hff, 3'd2, 6'd1, 7'd2, 8'ha5)); // tempo forgot
        send_cell(cell_of(8'hff, 8'h00, 8'hff, 3'd1, 6'd1, 7'd2, 8'ha5)); // freq adj forgot
        send_cell(cell_of(8'hff, 8'h00, 8'h8f, 3'd6, 6'd1, 7'd2, 8'ha5)); // silent command
        send_cell(cell_of(8'hff, 8'h00, 8'hff, 3'd6, 6'd1, 7'd2, 8'ha5)); // still silent
        // one-row pattern: an early tempo blocks the speed insert, break follows
        send_cell(cell_of(8'hff, 8'h00, 8'h53, 3'd0, 6'd0, 7'd1, 8'h00));
        send_cell(cell_of(8'hff, 8'h00, 8'hff, 3'd1, 6'd0, 7'd1, 8'h00));
        send_cell(cell_of(8'hff, 8'h00, 8'h2a, 3'd2, 6'd0, 7'd1, 8'h00));
        // zero row count, then rows past the end and a 32-row pattern with no break
        send_cell(cell_of(8'hff, 8'h00, 8'hff, 3'd0, 6'd0, 7'd0, 8'h00));
        send_cell(cell_of(8'hff, 8'h00, 8'h0f, 3'd0, 6'd63, 7'd127, 8'hff));
        send_cell(cell_of(8'hff, 8'h00, 8'hff, 3'd7, 6'd31, 7'd32, 8'hff));
        send_cell(cell_of(8'hff, 8'h00, 8'hff, 3'd0, 6'd30, 7'd31, 8'hff));
        send_cell(cell_of(8'hff, 8'h00, 8'hff, 3'd1, 6'd5, 7'd6, 8'hff));
        directed_cells = cells_sent;
    endtask

    initial begin
        cell_push <= 1'b0;
        cell_in   <= '0;
        rst_n     <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // slow receiver, moderately idle sender
        send_idle_pct = 35;
        recv_idle_pct = 81;
        send_directed();
        send_random_until(PHASE_ONE_END);
        wait_all_decoded();

        // slow sender, moderately idle receiver
        send_idle_pct = 81;
        recv_idle_pct = 35;
        send_random_until(PHASE_TWO_END);
        wait_all_decoded();

        // full rate; open with a long result hold so the queues back up
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_results  = 1'b1;
        send_random_until(TOTAL_CELLS);
        wait_all_decoded();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d cells: %0d directed, %0d across %0d patterns, %0d loose",
                 cells_sent, directed_cells, pattern_cells, pattern_count, loose_cells);
        $display("Checked %0d decoded cells over three idling mixes and a long hold",
                 results_done);
        if (results_pending != 0) begin
            $display("%0d decoded cells never arrived", results_pending);
        end
        if (fail_count == 0 && results_pending == 0) begin
            $display("[tracker_pattern_cell_decoder] OK");
        end else begin
            $display("[tracker_pattern_cell_decoder] ERROR");
        end
        $finish;
    end

    // Give up at a timeout far beyond the slowest passing run.
    initial begin
        #400000;
        $display("[tracker_pattern_cell_decoder] ERROR");
        $finish;
    end

endmodule
